// File: design/aksb_pkg.sv
// Shared types, constants and helpers for the alpha keyed sprite blit.
`default_nettype none
package aksb_pkg;

	localparam int CFG_W = 13;
	localparam int CNT_W = 12;
	localparam int PIX_W = 32;
	localparam int IDX_W = 24;
	localparam int ALPHA_LSB = 24;
	localparam int DEF_SCREEN_WIDTH = 1280;
	localparam int DEF_SCREEN_HEIGHT = 1024;
	localparam int Q_DEPTH = 2;
	localparam int Q_AW = 1;

	localparam logic [CFG_W-1:0] SIZE_MIN = 13'd1;
	localparam logic [CFG_W-1:0] SIZE_MAX = 13'd4096;

	localparam logic [1:0] REG_ORIGIN_X = 2'd0;
	localparam logic [1:0] REG_ORIGIN_Y = 2'd1;
	localparam logic [1:0] REG_IMAGE_WIDTH = 2'd2;
	localparam logic [1:0] REG_IMAGE_HEIGHT = 2'd3;

	typedef struct packed {
		logic [CFG_W-1:0] origin_x;
		logic [CFG_W-1:0] origin_y;
		logic [CFG_W-1:0] image_width;
		logic [CFG_W-1:0] image_height;
	} cfg_t;

	typedef struct packed {
		logic [PIX_W-1:0] pixel;
		logic [CNT_W-1:0] col;
		logic [CNT_W-1:0] row;
		logic last;
	} qent_t;

	function automatic logic [CFG_W-1:0] clamp_size(input logic [CFG_W-1:0] v);
		logic [CFG_W-1:0] r;
		r = v;
		if (v == '0) r = SIZE_MIN;
		else if (v > SIZE_MAX) r = SIZE_MAX;
		return r;
	endfunction

endpackage
`default_nettype wire

// File: design/aksb_if.sv
// Stream interfaces for source pixel beats and result beats.
`default_nettype none
interface aksb_pix_if import aksb_pkg::*; ();
	logic valid;
	logic ready;
	logic [PIX_W-1:0] source_pixel;
	modport source (output valid, output source_pixel, input ready);
	modport sink (input valid, input source_pixel, output ready);
endinterface

interface aksb_res_if import aksb_pkg::*; ();
	logic valid;
	logic ready;
	logic write_enable;
	logic [IDX_W-1:0] word_index;
	logic [PIX_W-1:0] pixel_value;
	logic out_of_bounds;
	logic last_of_image;
	modport source (output valid, output write_enable, output word_index,
		output pixel_value, output out_of_bounds, output last_of_image, input ready);
	modport sink (input valid, input write_enable, input word_index,
		input pixel_value, input out_of_bounds, input last_of_image, output ready);
endinterface
`default_nettype wire

// File: design/aksb_front.sv
// Front end: accepts pixel beats and tags each with its sprite position.
`default_nettype none
module aksb_front import aksb_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire cfg_t cfg,
	aksb_pix_if.sink src,
	output qent_t push_data,
	output logic push_valid,
	input wire logic push_ready
);
	logic [CNT_W-1:0] col_q;
	logic [CNT_W-1:0] row_q;
	logic [CFG_W-1:0] w;
	logic [CFG_W-1:0] h;
	logic last_col;
	logic last_row;
	logic take;

	always_comb begin
		w = clamp_size(cfg.image_width);
		h = clamp_size(cfg.image_height);
		last_col = ({1'b0, col_q} + CFG_W'(1)) >= w;
		last_row = ({1'b0, row_q} + CFG_W'(1)) >= h;
		push_data.pixel = src.source_pixel;
		push_data.col = col_q;
		push_data.row = row_q;
		push_data.last = last_col & last_row;
	end

	assign push_valid = src.valid;
	assign src.ready = push_ready;
	assign take = src.valid & push_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (take) begin
			if (last_col) begin
				col_q <= '0;
				row_q <= last_row ? '0 : row_q + CNT_W'(1);
			end else begin
				col_q <= col_q + CNT_W'(1);
			end
		end
	end
endmodule
`default_nettype wire

// File: design/aksb_queue.sv
// Two-entry queue between the front end and the address back end.
`default_nettype none
module aksb_queue import aksb_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire qent_t push_data,
	input wire logic push_valid,
	output logic push_ready,
	output qent_t pop_data,
	output logic pop_valid,
	input wire logic pop_ready
);
	qent_t mem_q [Q_DEPTH];
	logic [Q_AW-1:0] wr_ptr_q;
	logic [Q_AW-1:0] rd_ptr_q;
	logic [Q_AW:0] count_q;
	logic push;
	logic pop;

	assign push_ready = count_q != (Q_AW+1)'(Q_DEPTH);
	assign pop_valid = count_q != '0;
	assign pop_data = mem_q[rd_ptr_q];
	assign push = push_valid & push_ready;
	assign pop = pop_valid & pop_ready;

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + Q_AW'(1);
			if (pop) rd_ptr_q <= rd_ptr_q + Q_AW'(1);
			if (push & ~pop) count_q <= count_q + (Q_AW+1)'(1);
			else if (pop & ~push) count_q <= count_q - (Q_AW+1)'(1);
		end
	end
endmodule
`default_nettype wire

// File: design/aksb_back.sv
// Back end: word index multiply and add, bounds test and result register.
`default_nettype none
module aksb_back import aksb_pkg::*; #(
	parameter int SCREEN_WIDTH = DEF_SCREEN_WIDTH,
	parameter int SCREEN_HEIGHT = DEF_SCREEN_HEIGHT
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire cfg_t cfg,
	input wire qent_t pop_data,
	input wire logic pop_valid,
	output logic pop_ready,
	aksb_res_if.source dst
);
	localparam logic signed [CFG_W:0] SW_C = (CFG_W+1)'(SCREEN_WIDTH);
	localparam logic [CFG_W:0] SW_U = (CFG_W+1)'(SCREEN_WIDTH);
	localparam logic [CFG_W:0] SH_U = (CFG_W+1)'(SCREEN_HEIGHT);

	logic valid_s1;
	logic [PIX_W-1:0] pixel_s1;
	logic [CNT_W-1:0] col_s1;
	logic last_s1;
	logic signed [2*CFG_W+1:0] prod_s1;

	logic valid_s2;
	logic we_s2;
	logic [IDX_W-1:0] idx_s2;
	logic [PIX_W-1:0] pixel_s2;
	logic oob_s2;
	logic last_s2;

	logic ready_s1;
	logic ready_s2;
	logic signed [CFG_W:0] row_sum;
	logic [CFG_W-1:0] w;
	logic [CFG_W-1:0] h;
	logic oob;
	logic [IDX_W-1:0] idx;

	assign ready_s2 = ~valid_s2 | dst.ready;
	assign ready_s1 = ~valid_s1 | ready_s2;
	assign pop_ready = ready_s1;

	always_comb begin
		row_sum = $signed({cfg.origin_y[CFG_W-1], cfg.origin_y}) +
			$signed({2'b00, pop_data.row});
		w = clamp_size(cfg.image_width);
		h = clamp_size(cfg.image_height);
		oob = cfg.origin_x[CFG_W-1] | cfg.origin_y[CFG_W-1] |
			(({1'b0, cfg.origin_x} + {1'b0, w}) > SW_U) |
			(({1'b0, cfg.origin_y} + {1'b0, h}) > SH_U);
		idx = prod_s1[IDX_W-1:0] +
			{{(IDX_W-CFG_W){cfg.origin_x[CFG_W-1]}}, cfg.origin_x} +
			{{(IDX_W-CNT_W){1'b0}}, col_s1};
	end

	always_ff @(posedge clk) begin
		if (ready_s1 & pop_valid) begin
			pixel_s1 <= pop_data.pixel;
			col_s1 <= pop_data.col;
			last_s1 <= pop_data.last;
			prod_s1 <= (2*CFG_W+2)'(row_sum) * (2*CFG_W+2)'(SW_C);
		end
		if (ready_s2 & valid_s1) begin
			pixel_s2 <= pixel_s1;
			idx_s2 <= idx;
			oob_s2 <= oob;
			we_s2 <= (pixel_s1[PIX_W-1:ALPHA_LSB] != '0) & ~oob;
			last_s2 <= last_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (ready_s1) valid_s1 <= pop_valid;
			if (ready_s2) valid_s2 <= valid_s1;
		end
	end

	assign dst.valid = valid_s2;
	assign dst.write_enable = we_s2;
	assign dst.word_index = idx_s2;
	assign dst.pixel_value = pixel_s2;
	assign dst.out_of_bounds = oob_s2;
	assign dst.last_of_image = last_s2;
endmodule
`default_nettype wire

// File: design/alpha_keyed_sprite_blit.sv
// Top level of the alpha keyed sprite blit address generator.
// Program origin_x, origin_y, image_width and image_height through the
// cfg_we / cfg_index / cfg_data port while the block is idle, then stream
// the sprite's ARGB pixels in row-major order on src, one pixel per beat.
// Each pixel beat yields one result beat on dst: the framebuffer word index,
// the pixel unchanged, a write enable set for nonzero alpha on an on-screen
// sprite, the out-of-bounds flag and a last-of-image marker.
// Throughput is one beat per cycle while dst is ready. An accepted pixel is
// written to the queue, moves from there into the multiply stage register and
// then into the dst register, from which its result beat is offered.
// The index multiply by the screen width is the one registered multiplier.
// A two-entry queue parts the counting front end from the address back end,
// so src keeps flowing while a result waits; when dst stalls the back end
// holds, the queue fills and src ready drops once both entries are held.
// Reset clears the position counters, the queue and the pipeline valids and
// returns the registers to origin zero and a one by one sprite. Register
// writes leave the counters untouched.
`default_nettype none
module alpha_keyed_sprite_blit import aksb_pkg::*; #(
	parameter int SCREEN_WIDTH = DEF_SCREEN_WIDTH,
	parameter int SCREEN_HEIGHT = DEF_SCREEN_HEIGHT
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_we,
	input wire logic [1:0] cfg_index,
	input wire logic [CFG_W-1:0] cfg_data,
	aksb_pix_if.sink src,
	aksb_res_if.source dst
);
	cfg_t cfg_q;
	qent_t push_data;
	qent_t pop_data;
	logic push_valid;
	logic push_ready;
	logic pop_valid;
	logic pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.origin_x <= '0;
			cfg_q.origin_y <= '0;
			cfg_q.image_width <= SIZE_MIN;
			cfg_q.image_height <= SIZE_MIN;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_ORIGIN_X: cfg_q.origin_x <= cfg_data;
				REG_ORIGIN_Y: cfg_q.origin_y <= cfg_data;
				REG_IMAGE_WIDTH: cfg_q.image_width <= cfg_data;
				REG_IMAGE_HEIGHT: cfg_q.image_height <= cfg_data;
			endcase
		end
	end

	aksb_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_q),
		.src(src),
		.push_data(push_data),
		.push_valid(push_valid),
		.push_ready(push_ready)
	);

	aksb_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push_data(push_data),
		.push_valid(push_valid),
		.push_ready(push_ready),
		.pop_data(pop_data),
		.pop_valid(pop_valid),
		.pop_ready(pop_ready)
	);

	aksb_back #(
		.SCREEN_WIDTH(SCREEN_WIDTH),
		.SCREEN_HEIGHT(SCREEN_HEIGHT)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_q),
		.pop_data(pop_data),
		.pop_valid(pop_valid),
		.pop_ready(pop_ready),
		.dst(dst)
	);
endmodule
`default_nettype wire
